### hdl/bc1_pkg.sv
`timescale 1ns / 1ps

package bc1_pkg;

  localparam int BLOCK_TEXELS = 16;
  localparam int TEXEL_W      = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int COORD_W      = 12;
  localparam int BLOCK_POS_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0]  DIM_RESET        = 13'd4096;

  localparam logic [TEXEL_W-1:0] TEXEL_LAST = 4'(BLOCK_TEXELS - 1);

  // palette selector codes
  typedef enum logic [1:0] {
    SEL_E0   = 2'd0,
    SEL_E1   = 2'd1,
    SEL_MID  = 2'd2,
    SEL_LAST = 2'd3
  } sel_code_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // expanded endpoints, registered at the front
  typedef struct packed {
    rgb_t                   c0;
    rgb_t                   c1;
    logic                   four;
    logic [31:0]            sel;
    logic [BLOCK_POS_W-1:0] col;
    logic [BLOCK_POS_W-1:0] row;
  } ends_t;

  // fully resolved block as held in the queue
  typedef struct packed {
    rgb_t [3:0]             palette;
    logic [31:0]            sel;
    logic [BLOCK_POS_W-1:0] col;
    logic [BLOCK_POS_W-1:0] row;
  } block_t;

  // c*255/31 truncated: c*255 times a 2^-20 reciprocal of 31, exact for 5-bit c
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [28:0] prod;
    prod = 29'(c) * 29'd8625630;
    return prod[27:20];
  endfunction

  // c*255/63 truncated, same scheme with a reciprocal of 63
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [28:0] prod;
    prod = 29'(c) * 29'd4244475;
    return prod[27:20];
  endfunction

  // (2a+b)/3 truncated; 683/2048 is exact for sums below 768
  function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
    logic [9:0]  n;
    logic [19:0] prod;
    n    = {1'b0, a, 1'b0} + 10'(b);
    prod = 20'(n) * 20'd683;
    return prod[18:11];
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] n;
    n = 9'(a) + 9'(b);
    return n[8:1];
  endfunction

endpackage

### hdl/bc1_front.sv
`timescale 1ns / 1ps

module bc1_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [15:0]                         first_endpoint,
  input  logic [15:0]                         second_endpoint,
  input  logic [31:0]                         selector_bits,
  input  logic [bc1_pkg::BLOCK_POS_W-1:0]     block_column,
  input  logic [bc1_pkg::BLOCK_POS_W-1:0]     block_row,
  output logic                                blk_valid,
  input  logic                                blk_ready,
  output bc1_pkg::block_t                     blk
);

  logic            s1_valid;
  bc1_pkg::ends_t  s1;
  logic            accept;

  assign full   = s1_valid && !blk_ready;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (blk_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.c0.r <= bc1_pkg::expand5(first_endpoint[15:11]);
      s1.c0.g <= bc1_pkg::expand6(first_endpoint[10:5]);
      s1.c0.b <= bc1_pkg::expand5(first_endpoint[4:0]);
      s1.c1.r <= bc1_pkg::expand5(second_endpoint[15:11]);
      s1.c1.g <= bc1_pkg::expand6(second_endpoint[10:5]);
      s1.c1.b <= bc1_pkg::expand5(second_endpoint[4:0]);
      s1.four <= first_endpoint > second_endpoint;
      s1.sel  <= selector_bits;
      s1.col  <= block_column;
      s1.row  <= block_row;
    end
  end

  // palette build; the queue entry registers it
  always_comb begin
    blk.palette[bc1_pkg::SEL_E0] = s1.c0;
    blk.palette[bc1_pkg::SEL_E1] = s1.c1;
    if (s1.four) begin
      blk.palette[bc1_pkg::SEL_MID].r  = bc1_pkg::third(s1.c0.r, s1.c1.r);
      blk.palette[bc1_pkg::SEL_MID].g  = bc1_pkg::third(s1.c0.g, s1.c1.g);
      blk.palette[bc1_pkg::SEL_MID].b  = bc1_pkg::third(s1.c0.b, s1.c1.b);
      blk.palette[bc1_pkg::SEL_LAST].r = bc1_pkg::third(s1.c1.r, s1.c0.r);
      blk.palette[bc1_pkg::SEL_LAST].g = bc1_pkg::third(s1.c1.g, s1.c0.g);
      blk.palette[bc1_pkg::SEL_LAST].b = bc1_pkg::third(s1.c1.b, s1.c0.b);
    end else begin
      blk.palette[bc1_pkg::SEL_MID].r  = bc1_pkg::half(s1.c0.r, s1.c1.r);
      blk.palette[bc1_pkg::SEL_MID].g  = bc1_pkg::half(s1.c0.g, s1.c1.g);
      blk.palette[bc1_pkg::SEL_MID].b  = bc1_pkg::half(s1.c0.b, s1.c1.b);
      blk.palette[bc1_pkg::SEL_LAST]   = '0;
    end
    blk.sel = s1.sel;
    blk.col = s1.col;
    blk.row = s1.row;
  end

  assign blk_valid = s1_valid;

endmodule

### hdl/bc1_queue.sv
`timescale 1ns / 1ps

module bc1_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bc1_pkg::block_t in_blk,
  output logic            out_valid,
  input  logic            out_pop,
  output bc1_pkg::block_t out_blk
);

  localparam int PtrW   = (bc1_pkg::QUEUE_DEPTH > 1) ? $clog2(bc1_pkg::QUEUE_DEPTH) : 1;
  localparam int CountW = $clog2(bc1_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]   PtrLast = PtrW'(bc1_pkg::QUEUE_DEPTH - 1);
  localparam logic [CountW-1:0] CountFull = CountW'(bc1_pkg::QUEUE_DEPTH);

  bc1_pkg::block_t entries [bc1_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;
  logic              wr;
  logic              rd;

  assign in_ready  = count != CountFull;
  assign out_valid = count != '0;
  assign wr        = in_valid && in_ready;
  assign rd        = out_pop && out_valid;
  assign out_blk   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= in_blk;
    end
  end

endmodule

### hdl/bc1_back.sv
`timescale 1ns / 1ps

module bc1_back #(
  parameter int DIM_W = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          blk_valid,
  output logic                          blk_pop,
  input  bc1_pkg::block_t               blk,
  input  logic [DIM_W-1:0]              dim_width,
  input  logic [DIM_W-1:0]              dim_height,
  output logic                          empty,
  input  logic                          pop,
  output logic [bc1_pkg::COORD_W-1:0]   pixel_x,
  output logic [bc1_pkg::COORD_W-1:0]   pixel_y,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic                          inside_image,
  output logic                          last_texel
);

  logic                            out_valid;
  logic                            out_ready;
  logic                            take;
  logic [bc1_pkg::TEXEL_W-1:0]     texel;
  bc1_pkg::sel_code_t              code;
  bc1_pkg::rgb_t                   color;
  logic [bc1_pkg::COORD_W-1:0]     px;
  logic [bc1_pkg::COORD_W-1:0]     py;

  assign out_ready = !out_valid || pop;
  assign take      = blk_valid && out_ready;
  assign blk_pop   = take && (texel == bc1_pkg::TEXEL_LAST);
  assign empty     = !out_valid;

  always_comb begin
    code = bc1_pkg::sel_code_t'(blk.sel[{texel, 1'b0} +: 2]);
    case (code)
      bc1_pkg::SEL_E0:   color = blk.palette[0];
      bc1_pkg::SEL_E1:   color = blk.palette[1];
      bc1_pkg::SEL_MID:  color = blk.palette[2];
      bc1_pkg::SEL_LAST: color = blk.palette[3];
      default:           color = blk.palette[0];
    endcase
    px = {blk.col, texel[1:0]};
    py = {blk.row, texel[3:2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      texel     <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      texel     <= texel + 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_x      <= px;
      pixel_y      <= py;
      red          <= color.r;
      green        <= color.g;
      blue         <= color.b;
      inside_image <= (DIM_W'(px) < dim_width) && (DIM_W'(py) < dim_height);
      last_texel   <= texel == bc1_pkg::TEXEL_LAST;
    end
  end

endmodule

### hdl/bc1_block_texel_decoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake       Transfer when
// input     in         push / full     push && !full
// result    out        empty / pop     pop && !empty
// config    in         cfg_we          cfg_we (index 0 width, 1 height)
//
// One block yields 16 texels from the back-end texel counter, one per cycle while
// pop stays high. The first texel passes the front register, a queue entry and the
// output register. Reset clears the front register, the two-entry block queue,
// the texel counter and sets both dimensions to 4096. full rises while the front
// register waits on a full queue; pop low holds the current texel in place.

module bc1_block_texel_decoder #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [15:0]                       first_endpoint,
  input  logic [15:0]                       second_endpoint,
  input  logic [31:0]                       selector_bits,
  input  logic [bc1_pkg::BLOCK_POS_W-1:0]   block_column,
  input  logic [bc1_pkg::BLOCK_POS_W-1:0]   block_row,
  output logic                              empty,
  input  logic                              pop,
  output logic [bc1_pkg::COORD_W-1:0]       pixel_x,
  output logic [bc1_pkg::COORD_W-1:0]       pixel_y,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic                              inside_image,
  output logic                              last_texel,
  input  logic                              cfg_we,
  input  logic [bc1_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bc1_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int MaxW  = $clog2(MAX_DIMENSION + 1);
  localparam int DimW  = (MaxW > bc1_pkg::CFG_DATA_W) ? MaxW : bc1_pkg::CFG_DATA_W;
  localparam logic [DimW-1:0] DimMax = DimW'(MAX_DIMENSION);

  logic [bc1_pkg::CFG_DATA_W-1:0] image_width;
  logic [bc1_pkg::CFG_DATA_W-1:0] image_height;
  logic [DimW-1:0]                width_ext;
  logic [DimW-1:0]                height_ext;
  logic [DimW-1:0]                dim_width;
  logic [DimW-1:0]                dim_height;

  logic            f_valid;
  logic            f_ready;
  bc1_pkg::block_t f_blk;
  logic            q_valid;
  logic            q_pop;
  bc1_pkg::block_t q_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bc1_pkg::DIM_RESET;
      image_height <= bc1_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bc1_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bc1_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_ext  = DimW'(image_width);
  assign height_ext = DimW'(image_height);
  assign dim_width  = (width_ext > DimMax) ? DimMax : width_ext;
  assign dim_height = (height_ext > DimMax) ? DimMax : height_ext;

  bc1_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .first_endpoint  (first_endpoint),
    .second_endpoint (second_endpoint),
    .selector_bits   (selector_bits),
    .block_column    (block_column),
    .block_row       (block_row),
    .blk_valid       (f_valid),
    .blk_ready       (f_ready),
    .blk             (f_blk)
  );

  bc1_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_blk    (f_blk),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_blk   (q_blk)
  );

  bc1_back #(
    .DIM_W (DimW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .blk_valid    (q_valid),
    .blk_pop      (q_pop),
    .blk          (q_blk),
    .dim_width    (dim_width),
    .dim_height   (dim_height),
    .empty        (empty),
    .pop          (pop),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .inside_image (inside_image),
    .last_texel   (last_texel)
  );

endmodule

### hdl/bc1_checker.sv
`timescale 1ns / 1ps

module bc1_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             empty,
  input logic                             pop,
  input logic [bc1_pkg::COORD_W-1:0]      pixel_x,
  input logic [bc1_pkg::COORD_W-1:0]      pixel_y,
  input logic [7:0]                       red,
  input logic [7:0]                       green,
  input logic [7:0]                       blue,
  input logic                             inside_image,
  input logic                             last_texel
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // last texel is the bottom-right corner of its block
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_texel) |-> (pixel_x[1:0] == 2'd3 && pixel_y[1:0] == 2'd3))
    else $error("last_texel off the block corner");

  // a stalled texel holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable({pixel_x, pixel_y, red, green, blue,
                                              inside_image, last_texel})))
    else $error("stalled texel changed");

  // within a block the next texel follows at once, one column on
  a_next_texel: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_texel) |=>
      (!empty && pixel_x[1:0] == ($past(pixel_x[1:0]) + 2'd1)))
    else $error("texel sequence broken");

endmodule

bind bc1_block_texel_decoder bc1_checker u_bc1_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .pixel_x      (pixel_x),
  .pixel_y      (pixel_y),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .inside_image (inside_image),
  .last_texel   (last_texel)
);
